### sv/i2cmbs_pkg.sv
// Package with the phase encoding, command codes and field layout of the I2C bit sequencer.
package i2cmbs_pkg;

  // Bus phase of the sequencer; each accepted request advances one phase.
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST1     = 5'd1,
    PH_ST2     = 5'd2,
    PH_SP1     = 5'd3,
    PH_SP2     = 5'd4,
    PH_WR_HI   = 5'd5,
    PH_WR_LO   = 5'd6,
    PH_RD_HI   = 5'd7,
    PH_RD_SMP  = 5'd8,
    PH_RD_LO   = 5'd9,
    PH_AK_HI   = 5'd10,
    PH_AK_LO   = 5'd11,
    PH_WA_HI   = 5'd12,
    PH_WA_POLL = 5'd13
  } phase_e;

  // Command codes carried in the operation field.
  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_WRITE    = 3'd2,
    OP_READ     = 3'd3,
    OP_WAIT_ACK = 3'd4
  } op_e;

  localparam int unsigned InTdataW  = 16;
  localparam int unsigned InTuserW  = 4;
  localparam int unsigned OutTdataW = 16;

  localparam logic [7:0] AckTimeoutReset = 8'd250;
  localparam logic [2:0] LastBitIndex    = 3'd7;

  // Bit positions of the result fields within the output tdata.
  localparam int unsigned OutSclBit    = 0;
  localparam int unsigned OutSdaBit    = 1;
  localparam int unsigned OutBusyBit   = 2;
  localparam int unsigned OutDoneBit   = 3;
  localparam int unsigned OutRxLsb     = 4;
  localparam int unsigned OutAckErrBit = 12;

  // One result item as it leaves the block.
  typedef struct packed {
    logic       ack_error;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } result_t;

endpackage

### sv/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: one bus phase per accepted tick request.
//
// Usage: every request on the slave stream is one phase tick from the bus clock
// divider. It carries the sampled SDA level and, while the block is idle, an
// optional command (start, stop, write byte, read byte with ACK or NACK, wait
// for ACK). For every accepted request exactly one result appears on the master
// stream: the SCL and SDA drive levels after the tick, busy, done, the last read
// byte and the acknowledge error flag.
// The result of a request accepted at one edge is registered and valid from the
// next cycle. Throughput is one request per cycle while the receiver takes each
// result; the single phase update between the sequencer state registers and the
// output register allows this rate.
// The acknowledge timeout register is written through cfg_we_i/cfg_wdata_i and
// should only be changed while the sequencer is idle.
// Reset puts the sequencer in idle with both lines released, the read byte and
// error flag cleared, the timeout limit at 250 and the output register empty.
// When the receiver stalls, the result waits in the output register and a new
// request is only taken in the cycle in which that result is taken.
module i2c_master_bit_sequencer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration: acknowledge timeout limit.
  input  logic                               cfg_we_i,
  input  logic [7:0]                         cfg_wdata_i,
  // Tick requests.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero.
  input  logic [i2cmbs_pkg::InTdataW-1:0]    s_axis_tdata,
  // tuser: [0] cmd_valid, [3:1] operation.
  input  logic [i2cmbs_pkg::InTuserW-1:0]    s_axis_tuser,
  // Results.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
  //        [11:4] rx_byte, [12] ack_error, [15:13] zero.
  output logic [i2cmbs_pkg::OutTdataW-1:0]   m_axis_tdata
);
  import i2cmbs_pkg::*;

  // Sequencer state.
  phase_e     phase_q, phase_d;
  logic [2:0] bit_idx_q, bit_idx_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] wait_cnt_q, wait_cnt_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       ack_choice_q, ack_choice_d;
  logic       timeout_q, timeout_d;
  logic [7:0] rx_hold_q, rx_hold_d;
  logic [7:0] limit_q;
  logic       done;

  // Output register.
  logic       out_valid_q;
  result_t    out_q;
  result_t    res;

  // Request fields.
  logic       cmd_valid;
  op_e        op;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;
  logic       in_fire;

  assign cmd_valid = s_axis_tuser[0];
  assign op        = op_e'(s_axis_tuser[3:1]);
  assign tx_byte   = s_axis_tdata[7:0];
  assign send_ack  = s_axis_tdata[8];
  assign sda_in    = s_axis_tdata[9];

  // A new request is taken whenever the output register is empty or being drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Phase update for one tick.
  always_comb begin
    phase_d      = phase_q;
    bit_idx_d    = bit_idx_q;
    shift_d      = shift_q;
    wait_cnt_d   = wait_cnt_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    ack_choice_d = ack_choice_q;
    timeout_d    = timeout_q;
    rx_hold_d    = rx_hold_q;
    done         = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (cmd_valid) begin
          case (op)
            OP_START: begin
              sda_d     = 1'b1;
              scl_d     = 1'b1;
              phase_d   = PH_ST1;
              timeout_d = 1'b0;
            end
            OP_STOP: begin
              scl_d     = 1'b0;
              sda_d     = 1'b0;
              phase_d   = PH_SP1;
              timeout_d = 1'b0;
            end
            OP_WRITE: begin
              scl_d     = 1'b0;
              sda_d     = tx_byte[7];
              shift_d   = {tx_byte[6:0], 1'b0};
              bit_idx_d = '0;
              phase_d   = PH_WR_HI;
              timeout_d = 1'b0;
            end
            OP_READ: begin
              sda_d        = 1'b1;
              scl_d        = 1'b0;
              shift_d      = '0;
              bit_idx_d    = '0;
              ack_choice_d = send_ack;
              phase_d      = PH_RD_HI;
              timeout_d    = 1'b0;
            end
            OP_WAIT_ACK: begin
              sda_d      = 1'b1;
              wait_cnt_d = '0;
              phase_d    = PH_WA_HI;
              timeout_d  = 1'b0;
            end
            default: begin
              // Undefined codes leave the sequencer idle.
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
      PH_ST1: begin
        sda_d   = 1'b0;
        phase_d = PH_ST2;
      end
      PH_ST2: begin
        scl_d   = 1'b0;
        phase_d = PH_IDLE;
        done    = 1'b1;
      end
      PH_SP1: begin
        scl_d   = 1'b1;
        phase_d = PH_SP2;
      end
      PH_SP2: begin
        sda_d   = 1'b1;
        phase_d = PH_IDLE;
        done    = 1'b1;
      end
      PH_WR_HI: begin
        scl_d   = 1'b1;
        phase_d = PH_WR_LO;
      end
      PH_WR_LO: begin
        scl_d = 1'b0;
        if (bit_idx_q == LastBitIndex) begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end else begin
          bit_idx_d = bit_idx_q + 3'd1;
          sda_d     = shift_q[7];
          shift_d   = {shift_q[6:0], 1'b0};
          phase_d   = PH_WR_HI;
        end
      end
      PH_RD_HI: begin
        scl_d   = 1'b1;
        phase_d = PH_RD_SMP;
      end
      PH_RD_SMP: begin
        shift_d = {shift_q[6:0], sda_in};
        phase_d = PH_RD_LO;
      end
      PH_RD_LO: begin
        scl_d = 1'b0;
        if (bit_idx_q == LastBitIndex) begin
          // ACK drives SDA low, NACK leaves it released.
          sda_d   = !ack_choice_q;
          phase_d = PH_AK_HI;
        end else begin
          bit_idx_d = bit_idx_q + 3'd1;
          phase_d   = PH_RD_HI;
        end
      end
      PH_AK_HI: begin
        scl_d   = 1'b1;
        phase_d = PH_AK_LO;
      end
      PH_AK_LO: begin
        scl_d     = 1'b0;
        rx_hold_d = shift_q;
        phase_d   = PH_IDLE;
        done      = 1'b1;
      end
      PH_WA_HI: begin
        scl_d   = 1'b1;
        phase_d = PH_WA_POLL;
      end
      PH_WA_POLL: begin
        if (!sda_in) begin
          scl_d   = 1'b0;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end else if (wait_cnt_q >= limit_q) begin
          // Timeout: flag the error and release the bus with a stop.
          timeout_d = 1'b1;
          scl_d     = 1'b0;
          sda_d     = 1'b0;
          phase_d   = PH_SP1;
        end else begin
          wait_cnt_d = wait_cnt_q + 8'd1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Result fields as they stand after this tick.
  always_comb begin
    res.scl_out   = scl_d;
    res.sda_out   = sda_d;
    res.busy_res  = (phase_d != PH_IDLE);
    res.done_res  = done;
    res.rx_byte   = rx_hold_d;
    res.ack_error = timeout_d;
  end

  // Sequencer state registers, advanced once per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_idx_q    <= '0;
      shift_q      <= '0;
      wait_cnt_q   <= '0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      ack_choice_q <= 1'b0;
      timeout_q    <= 1'b0;
      rx_hold_q    <= '0;
    end else if (in_fire) begin
      phase_q      <= phase_d;
      bit_idx_q    <= bit_idx_d;
      shift_q      <= shift_d;
      wait_cnt_q   <= wait_cnt_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      ack_choice_q <= ack_choice_d;
      timeout_q    <= timeout_d;
      rx_hold_q    <= rx_hold_d;
    end
  end

  // Acknowledge timeout limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= AckTimeoutReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - $bits(result_t)){1'b0}}, out_q};

endmodule

### sv/i2cmbs_checker.sv
// Port-level checker for the I2C bit sequencer, bound to the top level.
module i2cmbs_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [i2cmbs_pkg::OutTdataW-1:0]   m_axis_tdata
);
  import i2cmbs_pkg::*;

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The block never refuses a request while its output register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request refused with empty output register");

  // Every accepted request leaves a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  // A completing sequence leaves the sequencer idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OutDoneBit] |-> !m_axis_tdata[OutBusyBit])
    else $error("done reported while still busy");

  // After a timed-out acknowledge the stop has released both lines once idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OutAckErrBit] && !m_axis_tdata[OutBusyBit]
    |-> m_axis_tdata[OutSclBit] && m_axis_tdata[OutSdaBit])
    else $error("bus not released after acknowledge timeout");

endmodule

bind i2c_master_bit_sequencer i2cmbs_checker u_i2cmbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/tb_i2c_master_bit_sequencer.sv
// Self-checking testbench for the I2C master bit sequencer, with a line-level predictor.
module tb_i2c_master_bit_sequencer;
  import i2cmbs_pkg::*;

  // Operation codes that the sequencer must ignore.
  localparam logic [2:0] OP_BAD_LO = 3'd5;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  // Cycles without any transfer on either stream before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Length of the single long hold-off of the result receiver.
  localparam int HOLD_CYCLES = 300;

  // How the stimulus drives SDA during one command sequence.
  typedef enum {SDA_FREE, SDA_LOW, SDA_HIGH} line_mode_e;

  // One tick request as seen on the input stream.
  typedef struct {
    bit         cmd_v;
    logic [2:0] op;
    logic [7:0] tx;
    bit         ack;
    bit         sda;
  } tick_t;

  // One planned command for the directed part.
  typedef struct {
    logic [2:0] op;
    logic [7:0] tx;
    bit         ack;
    line_mode_e mode;
  } plan_t;

  // Tracks the bus lines the sequencer should drive and checks every result.
  class i2c_line_tracker;
    phase_e     ph;
    logic [2:0] bit_cnt;
    logic [7:0] shreg;
    logic [7:0] polls;
    logic [7:0] limit;
    bit         scl;
    bit         sda;
    bit         ack_sel;
    bit         ack_err;
    logic [7:0] rx_last;
    result_t    expected_lines[$];
    int         errors;
    int         checked;
    int         timeouts;
    int         op_seen[5];

    function new();
      ph       = PH_IDLE;
      bit_cnt  = '0;
      shreg    = '0;
      polls    = '0;
      limit    = AckTimeoutReset;
      scl      = 1'b1;
      sda      = 1'b1;
      ack_sel  = 1'b0;
      ack_err  = 1'b0;
      rx_last  = '0;
      errors   = 0;
      checked  = 0;
      timeouts = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function void set_limit(logic [7:0] v);
      limit = v;
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    function void start_stop();
      scl = 1'b0;
      sda = 1'b0;
      ph  = PH_SP1;
    endfunction

    // Advance one bus phase for an accepted request and queue the line state it leaves.
    function void note_tick(tick_t t);
      result_t r;
      bit      fin;
      bit      taken;
      fin   = 1'b0;
      taken = 1'b1;
      case (ph)
        PH_IDLE: begin
          if (t.cmd_v) begin
            case (t.op)
              OP_START: begin
                sda = 1'b1;
                scl = 1'b1;
                ph  = PH_ST1;
              end
              OP_STOP: start_stop();
              OP_WRITE: begin
                scl     = 1'b0;
                sda     = t.tx[7];
                shreg   = {t.tx[6:0], 1'b0};
                bit_cnt = '0;
                ph      = PH_WR_HI;
              end
              OP_READ: begin
                sda     = 1'b1;
                scl     = 1'b0;
                shreg   = '0;
                bit_cnt = '0;
                ack_sel = t.ack;
                ph      = PH_RD_HI;
              end
              OP_WAIT_ACK: begin
                sda   = 1'b1;
                polls = '0;
                ph    = PH_WA_HI;
              end
              default: taken = 1'b0;
            endcase
            if (taken) begin
              ack_err = 1'b0;
              op_seen[t.op]++;
            end
          end
        end
        PH_ST1: begin
          sda = 1'b0;
          ph  = PH_ST2;
        end
        PH_ST2: begin
          scl = 1'b0;
          ph  = PH_IDLE;
          fin = 1'b1;
        end
        PH_SP1: begin
          scl = 1'b1;
          ph  = PH_SP2;
        end
        PH_SP2: begin
          sda = 1'b1;
          ph  = PH_IDLE;
          fin = 1'b1;
        end
        PH_WR_HI: begin
          scl = 1'b1;
          ph  = PH_WR_LO;
        end
        PH_WR_LO: begin
          scl = 1'b0;
          if (bit_cnt == LastBitIndex) begin
            ph  = PH_IDLE;
            fin = 1'b1;
          end else begin
            bit_cnt = bit_cnt + 3'd1;
            sda     = shreg[7];
            shreg   = {shreg[6:0], 1'b0};
            ph      = PH_WR_HI;
          end
        end
        PH_RD_HI: begin
          scl = 1'b1;
          ph  = PH_RD_SMP;
        end
        PH_RD_SMP: begin
          shreg = {shreg[6:0], t.sda};
          ph    = PH_RD_LO;
        end
        PH_RD_LO: begin
          scl = 1'b0;
          if (bit_cnt == LastBitIndex) begin
            sda = !ack_sel;
            ph  = PH_AK_HI;
          end else begin
            bit_cnt = bit_cnt + 3'd1;
            ph      = PH_RD_HI;
          end
        end
        PH_AK_HI: begin
          scl = 1'b1;
          ph  = PH_AK_LO;
        end
        PH_AK_LO: begin
          scl     = 1'b0;
          rx_last = shreg;
          ph      = PH_IDLE;
          fin     = 1'b1;
        end
        PH_WA_HI: begin
          scl = 1'b1;
          ph  = PH_WA_POLL;
        end
        PH_WA_POLL: begin
          // SDA low acknowledges; otherwise count polls until the limit is used up.
          if (!t.sda) begin
            scl = 1'b0;
            ph  = PH_IDLE;
            fin = 1'b1;
          end else if (polls >= limit) begin
            ack_err = 1'b1;
            timeouts++;
            start_stop();
          end else begin
            polls = polls + 8'd1;
          end
        end
        default: ph = PH_IDLE;
      endcase
      r.scl_out   = scl;
      r.sda_out   = sda;
      r.busy_res  = (ph != PH_IDLE);
      r.done_res  = fin;
      r.rx_byte   = rx_last;
      r.ack_error = ack_err;
      expected_lines.push_back(r);
    endfunction

    // Compare one accepted result with the oldest expected line state.
    function void check_result(result_t act);
      result_t exp_r;
      checked++;
      if (expected_lines.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, act);
        return;
      end
      exp_r = expected_lines.pop_front();
      if (act.scl_out !== exp_r.scl_out) begin
        errors++;
        $display("%0t: scl_out expected %b actual %b", $time, exp_r.scl_out, act.scl_out);
      end
      if (act.sda_out !== exp_r.sda_out) begin
        errors++;
        $display("%0t: sda_out expected %b actual %b", $time, exp_r.sda_out, act.sda_out);
      end
      if (act.busy_res !== exp_r.busy_res) begin
        errors++;
        $display("%0t: busy expected %b actual %b", $time, exp_r.busy_res, act.busy_res);
      end
      if (act.done_res !== exp_r.done_res) begin
        errors++;
        $display("%0t: done expected %b actual %b", $time, exp_r.done_res, act.done_res);
      end
      if (act.rx_byte !== exp_r.rx_byte) begin
        errors++;
        $display("%0t: rx_byte expected %h actual %h", $time, exp_r.rx_byte, act.rx_byte);
      end
      if (act.ack_error !== exp_r.ack_error) begin
        errors++;
        $display("%0t: ack_error expected %b actual %b", $time, exp_r.ack_error,
                 act.ack_error);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic [InTuserW-1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;

  i2c_line_tracker sb;
  plan_t           plan[$];
  line_mode_e      line_mode;
  int              tx_calm;
  int              rx_calm;

  i2c_master_bit_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Gap before the next request or result transfer; now and then a stretch with no gaps at all.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(15, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Build the next tick request from the predicted phase of the sequencer.
  task automatic make_tick(output tick_t t);
    plan_t c;
    int    roll;
    t.cmd_v = 1'b0;
    t.op    = 3'($urandom_range(0, 7));
    t.tx    = 8'($urandom);
    t.ack   = 1'($urandom);
    t.sda   = 1'($urandom);
    if (sb.ph == PH_IDLE) begin
      if (plan.size() != 0) begin
        c         = plan.pop_front();
        t.cmd_v   = 1'b1;
        t.op      = c.op;
        t.tx      = c.tx;
        t.ack     = c.ack;
        line_mode = c.mode;
      end else begin
        roll = $urandom_range(0, 19);
        line_mode = SDA_FREE;
        if (roll >= 2) begin
          t.cmd_v = 1'b1;
          if (roll == 2) begin
            t.op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
          end else begin
            t.op = 3'($urandom_range(OP_START, OP_WAIT_ACK));
            roll = $urandom_range(0, 9);
            if (t.op == OP_WAIT_ACK && roll == 0) begin
              line_mode = SDA_HIGH;
            end else if (t.op == OP_READ && roll == 0) begin
              line_mode = SDA_HIGH;
            end else if (t.op == OP_READ && roll == 1) begin
              line_mode = SDA_LOW;
            end
          end
        end
      end
    end else begin
      // Commands offered while busy must be ignored by the sequencer.
      t.cmd_v = ($urandom_range(0, 7) == 0);
      case (line_mode)
        SDA_LOW:  t.sda = 1'b0;
        SDA_HIGH: t.sda = 1'b1;
        default: begin
          if (sb.ph == PH_WA_POLL) t.sda = ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  endtask

  // Offer one request and note it once the sequencer takes it.
  task automatic send_tick(input tick_t t);
    int gap;
    gap = draw_gap(tx_calm);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, t.sda, t.ack, t.tx};
    s_axis_tuser  <= {t.op, t.cmd_v};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_tick(t);
  endtask

  // Run the plan and n_items counted requests, then let the sequencer return to idle.
  task automatic run_phase(input int n_items);
    tick_t t;
    int    counted;
    counted = 0;
    while (plan.size() != 0 || counted < n_items) begin
      make_tick(t);
      if (sb.ph != PH_IDLE || (t.cmd_v && t.op <= OP_WAIT_ACK)) counted++;
      send_tick(t);
    end
    while (sb.ph != PH_IDLE) begin
      make_tick(t);
      send_tick(t);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Change the timeout limit once the sequencer is idle and all results are in.
  task automatic write_limit(input logic [7:0] v);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_limit(v);
  endtask

  // Result receiver: random stalls, with one long hold-off to back up the input.
  initial begin
    int gap;
    bit held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(rx_calm);
      if (!held && sb.checked > 400) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Result monitor and stall watchdog.
  initial begin
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(result_t'(m_axis_tdata[12:0]));
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        stall = 0;
      end else begin
        stall++;
      end
      if (stall >= STALL_LIMIT) begin
        $display("%0t: no request accepted for %0d cycles", $time, stall);
        $display("i2c_master_bit_sequencer verification failed");
        $finish;
      end
    end
  end

  // Main sequence: directed commands, then random phases at several timeout limits.
  initial begin
    sb            = new();
    tx_calm       = 0;
    rx_calm       = 0;
    line_mode     = SDA_FREE;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Every command at the reset limit, reads of all ones and all zeros, ignored codes.
    plan.push_back('{OP_START,    8'h00, 1'b0, SDA_FREE});
    plan.push_back('{OP_WRITE,    8'hA5, 1'b0, SDA_FREE});
    plan.push_back('{OP_WAIT_ACK, 8'h00, 1'b0, SDA_LOW});
    plan.push_back('{OP_READ,     8'h00, 1'b1, SDA_HIGH});
    plan.push_back('{OP_READ,     8'h00, 1'b0, SDA_LOW});
    plan.push_back('{OP_WRITE,    8'h5A, 1'b1, SDA_FREE});
    plan.push_back('{OP_WAIT_ACK, 8'hFF, 1'b1, SDA_FREE});
    plan.push_back('{OP_BAD_LO,   8'hFF, 1'b1, SDA_FREE});
    plan.push_back('{OP_BAD_HI,   8'h00, 1'b0, SDA_FREE});
    plan.push_back('{OP_STOP,     8'hFF, 1'b0, SDA_FREE});
    run_phase(0);

    // A zero limit times out on the first high poll.
    write_limit(8'd0);
    plan.push_back('{OP_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH});
    plan.push_back('{OP_WAIT_ACK, 8'h00, 1'b0, SDA_LOW});
    plan.push_back('{OP_START,    8'h00, 1'b0, SDA_FREE});
    run_phase(0);

    // The largest limit times out on the 256th high poll without wrapping.
    write_limit(8'd255);
    plan.push_back('{OP_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH});
    plan.push_back('{OP_STOP,     8'h00, 1'b0, SDA_FREE});
    run_phase(220);

    write_limit(8'($urandom_range(0, 15)));
    run_phase(220);
    write_limit(8'd1);
    run_phase(220);
    write_limit(8'($urandom_range(0, 255)));
    run_phase(220);
    write_limit(8'($urandom_range(2, 8)));
    run_phase(220);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("Run covered %0d ticks; commands start/stop/write/read/wait: %0d/%0d/%0d/%0d/%0d.",
             sb.checked, sb.op_seen[0], sb.op_seen[1], sb.op_seen[2], sb.op_seen[3],
             sb.op_seen[4]);
    $display("Acknowledge timeouts seen: %0d; mismatches: %0d.", sb.timeouts, sb.errors);
    if (sb.errors == 0) begin
      $display("i2c_master_bit_sequencer verification clean");
    end else begin
      $display("i2c_master_bit_sequencer verification failed");
    end
    $finish;
  end

endmodule
